// ===== sv/phia_pkg.sv =====
// Shared types, constants and tables for the polarized hyperon intensity amplitude core.
// Used by phia_cordic, phia_sqrt and the top level; depends on nothing.
package phia_pkg;

    localparam int CORDIC_STEPS = 15;
    localparam int CW           = 34;   // CORDIC x/y width, Q2.30 plus guard
    localparam int ZW           = 18;   // CORDIC residual angle width
    localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(652032874);

    localparam int MAG_W      = 38;     // |I| width, even
    localparam int SQRT_STEPS = MAG_W / 2;

    localparam int SIDE_DLY  = 14;      // side data delay to meet sine/cosine
    localparam int LAT       = 42;      // input word to output word
    localparam int CFG_IDX_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ALPHA   = 8'd0,
        REG_RHO111  = 8'd1,
        REG_RHO001  = 8'd2,
        REG_OX      = 8'd3,
        REG_PR      = 8'd4,
        REG_TA      = 8'd5,
        REG_OZ      = 8'd6,
        REG_POL_ANG = 8'd7
    } cfg_reg_t;

    typedef struct packed {
        logic        [15:0] pg;
        logic signed [32:0] term1;
        logic signed [34:0] inner;
        logic signed [34:0] ao;
    } side_t;

    // arctangent of 2^-i in binary angle units
    function automatic logic signed [ZW-1:0] atan_step(input int i);
        logic signed [ZW-1:0] a;
        case (i)
            0:       a = ZW'(8192);
            1:       a = ZW'(4836);
            2:       a = ZW'(2555);
            3:       a = ZW'(1297);
            4:       a = ZW'(651);
            5:       a = ZW'(326);
            6:       a = ZW'(163);
            7:       a = ZW'(81);
            8:       a = ZW'(41);
            9:       a = ZW'(20);
            10:      a = ZW'(10);
            11:      a = ZW'(5);
            12:      a = ZW'(3);
            13:      a = ZW'(1);
            14:      a = ZW'(1);
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

// ===== sv/phia_cordic.sv =====
// Pipelined sine/cosine of a 16-bit binary angle: quadrant fold, 15 CORDIC stages,
// quadrant rotation with round and clamp to Q1.15. Depends on phia_pkg.
module phia_cordic import phia_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic        [15:0] ang,
    output logic signed [15:0] cos_q,
    output logic signed [15:0] sin_q
);

    logic signed [CW-1:0] x_reg [0:CORDIC_STEPS];
    logic signed [CW-1:0] y_reg [0:CORDIC_STEPS];
    logic signed [ZW-1:0] z_reg [0:CORDIC_STEPS];
    logic        [1:0]    q_reg [0:CORDIC_STEPS];
    logic signed [15:0]   cos_reg;
    logic signed [15:0]   sin_reg;

    logic [15:0] ang_off;
    logic [1:0]  q0;
    logic [15:0] rr;

    assign ang_off = ang + 16'd8192;
    assign q0      = ang_off[15:14];
    assign rr      = ang - {q0, 14'd0};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= CORDIC_GAIN;
            y_reg[0] <= '0;
            z_reg[0] <= ZW'(signed'(rr));
            q_reg[0] <= q0;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!z_reg[i][ZW-1])
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - atan_step(i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + atan_step(i);
                end
                q_reg[i+1] <= q_reg[i];
            end
        end
    end

    // round by 2^15 and clamp; input is the sum already shifted
    function automatic logic signed [15:0] sat16(input logic signed [CW-15:0] v);
        logic fits;
        fits = (&v[CW-15:15]) | ~(|v[CW-15:15]);
        if (fits)
            return v[15:0];
        else if (v[CW-15])
            return 16'sh8000;
        else
            return 16'sh7FFF;
    endfunction

    logic signed [CW-1:0] c_full;
    logic signed [CW-1:0] s_full;
    logic signed [CW:0]   c_sum;
    logic signed [CW:0]   s_sum;
    logic signed [15:0]   cos_next;
    logic signed [15:0]   sin_next;

    always_comb
    begin
        case (q_reg[CORDIC_STEPS])
            2'd0:
            begin
                c_full = x_reg[CORDIC_STEPS];
                s_full = y_reg[CORDIC_STEPS];
            end
            2'd1:
            begin
                c_full = -y_reg[CORDIC_STEPS];
                s_full = x_reg[CORDIC_STEPS];
            end
            2'd2:
            begin
                c_full = -x_reg[CORDIC_STEPS];
                s_full = -y_reg[CORDIC_STEPS];
            end
            default:
            begin
                c_full = y_reg[CORDIC_STEPS];
                s_full = -x_reg[CORDIC_STEPS];
            end
        endcase
        c_sum    = (CW+1)'(c_full) + (CW+1)'(16384);
        s_sum    = (CW+1)'(s_full) + (CW+1)'(16384);
        cos_next = sat16(c_sum[CW:15]);
        sin_next = sat16(s_sum[CW:15]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_reg <= cos_next;
            sin_reg <= sin_next;
        end
    end

    assign cos_q = cos_reg;
    assign sin_q = sin_reg;

endmodule

// ===== sv/phia_sqrt.sv =====
// Pipelined integer square root, one result bit per stage, then round-half
// and saturate to 16 bits. Depends on phia_pkg.
module phia_sqrt import phia_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [MAG_W-1:0]  mag,
    output logic [15:0]       amplitude
);

    logic [MAG_W-1:0] v_reg [0:SQRT_STEPS-1];
    logic [MAG_W-1:0] r_reg [0:SQRT_STEPS-1];
    logic [15:0]      amp_reg;

    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_bit
        localparam logic [MAG_W-1:0] BIT = MAG_W'(1) << (2 * (SQRT_STEPS - 1 - k));

        logic [MAG_W-1:0] v_in;
        logic [MAG_W-1:0] r_in;
        logic [MAG_W-1:0] trial;

        if (k == 0)
        begin : g_first
            assign v_in = mag;
            assign r_in = '0;
        end
        else
        begin : g_rest
            assign v_in = v_reg[k-1];
            assign r_in = r_reg[k-1];
        end

        assign trial = r_in + BIT;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (v_in >= trial)
                begin
                    v_reg[k] <= v_in - trial;
                    r_reg[k] <= (r_in >> 1) + BIT;
                end
                else
                begin
                    v_reg[k] <= v_in;
                    r_reg[k] <= r_in >> 1;
                end
            end
        end
    end

    logic [MAG_W-1:0] rounded;

    assign rounded = (r_reg[SQRT_STEPS-1] + MAG_W'(1)) >> 1;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (|rounded[MAG_W-1:16])
                amp_reg <= 16'hFFFF;
            else
                amp_reg <= rounded[15:0];
        end
    end

    assign amplitude = amp_reg;

endmodule

// ===== sv/polarized_hyperon_intensity_amplitude_core.sv =====
// Throughput: one word per cycle; a stalled output word freezes the whole pipeline.
// The pipe depth comes from the 15 CORDIC stages and the 19 square root stages.
// Reset (rst_n low, asynchronous) clears the valid bits and all fit registers to 0.
// Top level; depends on phia_pkg, phia_cordic and phia_sqrt.
module polarized_hyperon_intensity_amplitude_core import phia_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // cos_theta_x, cos_theta_y, cos_theta_z, azimuth, beam_polarization
    input  logic [79:0]          s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // amplitude
    output logic [15:0]          m_tdata,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data
);

    logic signed [15:0] alpha_reg, r111_reg, r001_reg, ox_reg, pr_reg, ta_reg, oz_reg;
    logic        [15:0] pol_ang_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg   <= '0;
            r111_reg    <= '0;
            r001_reg    <= '0;
            ox_reg      <= '0;
            pr_reg      <= '0;
            ta_reg      <= '0;
            oz_reg      <= '0;
            pol_ang_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_ALPHA:   alpha_reg   <= cfg_data;
                REG_RHO111:  r111_reg    <= cfg_data;
                REG_RHO001:  r001_reg    <= cfg_data;
                REG_OX:      ox_reg      <= cfg_data;
                REG_PR:      pr_reg      <= cfg_data;
                REG_TA:      ta_reg      <= cfg_data;
                REG_OZ:      oz_reg      <= cfg_data;
                REG_POL_ANG: pol_ang_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    logic            en;
    logic [LAT-1:0]  vld_reg;

    assign en       = !vld_reg[LAT-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
    end

    // stage 1: capture, doubled rotated azimuth
    logic signed [15:0] cx1_reg, cy1_reg, cz1_reg;
    logic        [15:0] pg1_reg, d1_reg;
    logic        [15:0] phi;

    assign phi = s_tdata[63:48] + pol_ang_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cx1_reg <= s_tdata[15:0];
            cy1_reg <= s_tdata[31:16];
            cz1_reg <= s_tdata[47:32];
            pg1_reg <= s_tdata[79:64];
            d1_reg  <= {phi[14:0], 1'b0};
        end
    end

    // stages 2..5: the terms that do not need the angle
    logic signed [31:0] ac2_reg, mox2_reg, moz2_reg;
    logic        [15:0] pg2_reg, pg3_reg, pg4_reg;
    logic signed [47:0] pt1_3_reg, pta3_reg;
    logic signed [32:0] msum3_reg;
    logic signed [32:0] term1_4_reg;
    logic signed [34:0] inner4_reg;
    logic signed [48:0] pao4_reg;
    logic signed [47:0] t1_sum, ta_sum;
    logic signed [17:0] rsum;
    logic signed [48:0] ao_sum;
    side_t              side5;
    side_t              dly_reg [0:SIDE_DLY-1];

    assign t1_sum = pt1_3_reg + 48'sd16384;
    assign ta_sum = pta3_reg + 48'sd8192;
    assign rsum   = (18'(r111_reg) <<< 1) + 18'(r001_reg);
    assign ao_sum = pao4_reg + 49'sd8192;

    always_comb
    begin
        side5.pg    = pg4_reg;
        side5.term1 = term1_4_reg;
        side5.inner = inner4_reg;
        side5.ao    = ao_sum[48:14];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ac2_reg     <= cy1_reg * alpha_reg;
            mox2_reg    <= cx1_reg * ox_reg;
            moz2_reg    <= cz1_reg * oz_reg;
            pg2_reg     <= pg1_reg;

            pt1_3_reg   <= ac2_reg * pr_reg;
            pta3_reg    <= ac2_reg * ta_reg;
            msum3_reg   <= 33'(mox2_reg) + 33'(moz2_reg);
            pg3_reg     <= pg2_reg;

            term1_4_reg <= t1_sum[47:15];
            inner4_reg  <= (35'(rsum) <<< 15) + 35'(signed'(ta_sum[47:14]));
            pao4_reg    <= msum3_reg * alpha_reg;
            pg4_reg     <= pg3_reg;

            dly_reg[0]  <= side5;
            for (int k = 1; k < SIDE_DLY; k++)
                dly_reg[k] <= dly_reg[k-1];
        end
    end

    logic signed [15:0] cos_q, sin_q;

    phia_cordic u_cordic
    (
        .clk   (clk),
        .en    (en),
        .ang   (d1_reg),
        .cos_q (cos_q),
        .sin_q (sin_q)
    );

    // stage 19: polarization times cosine and sine
    side_t              s18;
    logic signed [16:0] pgs;
    logic signed [32:0] pc_full, ps_full;
    logic signed [17:0] pc19_reg, ps19_reg;
    logic signed [32:0] term1_19_reg, term1_20_reg, term1_21_reg;
    logic signed [34:0] inner19_reg, ao19_reg;

    assign s18     = dly_reg[SIDE_DLY-1];
    assign pgs     = {1'b0, s18.pg};
    assign pc_full = pgs * cos_q + 33'sd16384;
    assign ps_full = pgs * sin_q + 33'sd16384;

    // stage 20: split products, stage 21: recombine and round
    logic signed [17:0] inner_hi, inner_lo, ao_hi, ao_lo;
    logic signed [35:0] p2h_reg, p2l_reg, p3h_reg, p3l_reg;
    logic signed [53:0] t2_full, t3_full;
    logic signed [36:0] term2_reg, term3_reg;

    assign inner_hi = inner19_reg[34:17];
    assign inner_lo = {1'b0, inner19_reg[16:0]};
    assign ao_hi    = ao19_reg[34:17];
    assign ao_lo    = {1'b0, ao19_reg[16:0]};
    assign t2_full  = (54'(p2h_reg) <<< 17) + 54'(p2l_reg) + 54'sd65536;
    assign t3_full  = (54'(p3h_reg) <<< 17) + 54'(p3l_reg) + 54'sd65536;

    // stage 22: intensity and magnitude
    logic signed [38:0] inten;
    logic [MAG_W-1:0]   mag_reg;

    assign inten = 39'sd268435456 + 39'(term1_21_reg) - 39'(term2_reg) + 39'(term3_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pc19_reg     <= pc_full[32:15];
            ps19_reg     <= ps_full[32:15];
            term1_19_reg <= s18.term1;
            inner19_reg  <= s18.inner;
            ao19_reg     <= s18.ao;

            p2h_reg      <= pc19_reg * inner_hi;
            p2l_reg      <= pc19_reg * inner_lo;
            p3h_reg      <= ps19_reg * ao_hi;
            p3l_reg      <= ps19_reg * ao_lo;
            term1_20_reg <= term1_19_reg;

            term2_reg    <= t2_full[53:17];
            term3_reg    <= t3_full[53:17];
            term1_21_reg <= term1_20_reg;

            if (inten[38])
                mag_reg <= MAG_W'(-inten);
            else
                mag_reg <= MAG_W'(inten);
        end
    end

    phia_sqrt u_sqrt
    (
        .clk       (clk),
        .en        (en),
        .mag       (mag_reg),
        .amplitude (m_tdata)
    );

`ifndef SYNTH
    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |=> $stable(vld_reg))
        else $error("valid pipe moved while stalled");

    a_mag_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[21] |-> (mag_reg[MAG_W-1:MAG_W-3] == 3'd0))
        else $error("intensity magnitude out of range");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(vld_reg[LAT-2]))
        else $error("output word without a word in the last stage");
`endif

endmodule
